@@ src/ptc_pkg.sv @@
// Package: shared types, constants and helper functions for pressure/temperature compensation
package ptc_pkg;

  localparam logic [31:0] PRESS_OFFS   = 32'd64000;
  localparam logic [31:0] PRESS_BASE   = 32'd1048576;
  localparam logic [31:0] PRESS_SCALE  = 32'd3125;
  localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;
  localparam logic [31:0] VAR1_OFFS    = 32'd32768;
  localparam logic [31:0] ROUND_CENTI  = 32'd128;

  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [1:0] {
    REG_TEMP_CALIB    = 2'd0,
    REG_PRESS_CALIB_A = 2'd1,
    REG_PRESS_CALIB_B = 2'd2,
    REG_PRESS_CALIB_C = 2'd3
  } reg_idx_t;

  // calibration words, already extended to 32 bits
  typedef struct packed {
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] p5;
    logic [31:0] p6;
    logic [31:0] p7;
    logic [31:0] p8;
    logic [31:0] p9;
  } calib_t;

  // results that ride alongside the divider
  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] cent;
    logic        halve;
    logic        bad;
  } side_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
    logic signed [31:0] xs;
    xs = x;
    return 32'(xs >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

@@ src/ptc_if.sv @@
// Interfaces: sample and result channels
interface ptc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source(output valid, raw_temperature, raw_pressure, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface ptc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] fine_temperature;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_pa;
  logic        pressure_invalid;
  modport source(output valid, fine_temperature, temperature_centi, pressure_pa,
                 pressure_invalid, input ready);
  modport sink(input valid, fine_temperature, temperature_centi, pressure_pa,
               pressure_invalid, output ready);
endinterface

@@ src/ptc_front.sv @@
// Front pipeline: temperature terms and pressure terms up to the divider inputs
module ptc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ptc_pkg::calib_t   cal,
  input  logic              in_valid,
  input  logic [19:0]       rt,
  input  logic [19:0]       rp,
  output logic              out_valid,
  output logic [31:0]       num,
  output logic [31:0]       divisor,
  output ptc_pkg::side_t    side
);
  import ptc_pkg::*;

  logic        v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11;
  logic [31:0] rp1, rp2, rp3, rp4, rp5, rp6, rp7, rp8, rp9;
  logic [31:0] x1, d1, m2, dd2, a3, m3, fine4;
  logic [31:0] fine5, cent5, pa5;
  logic [31:0] qq6, ap5_6, ap2_6, b6_7, t13_7, ap5_7, ap2_7;
  logic [31:0] bb8, a8, am9, bb9, div10, pn10, pm11, div11;
  side_t       s6, s7, s8, s9, s10, s11;
  logic [31:0] q5;
  logic [31:0] rt32;

  assign rt32 = {12'd0, rt};
  assign q5   = asr(pa5, 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11} <=
        {in_valid, v1, v2, v3, v4, v5, v6, v7, v8, v9, v10};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // temperature
      x1    <= (rt32 >> 3) - (cal.t1 << 1);
      d1    <= (rt32 >> 4) - cal.t1;
      rp1   <= {12'd0, rp};
      m2    <= 32'(x1 * cal.t2);
      dd2   <= 32'(d1 * d1);
      rp2   <= rp1;
      a3    <= asr(m2, 11);
      m3    <= 32'(asr(dd2, 12) * cal.t3);
      rp3   <= rp2;
      fine4 <= a3 + asr(m3, 14);
      rp4   <= rp3;
      // pressure
      fine5 <= fine4;
      cent5 <= asr(32'(fine4 * 32'd5) + ROUND_CENTI, 8);
      pa5   <= asr(fine4, 1) - PRESS_OFFS;
      rp5   <= rp4;
      qq6   <= 32'(q5 * q5);
      ap5_6 <= 32'(pa5 * cal.p5);
      ap2_6 <= 32'(cal.p2 * pa5);
      s6    <= '{fine: fine5, cent: cent5, halve: 1'b0, bad: 1'b0};
      rp6   <= rp5;
      b6_7  <= 32'(asr(qq6, 11) * cal.p6);
      t13_7 <= 32'(cal.p3 * asr(qq6, 13));
      ap5_7 <= ap5_6;
      ap2_7 <= ap2_6;
      s7    <= s6;
      rp7   <= rp6;
      bb8   <= asr(b6_7 + (ap5_7 << 1), 2) + (cal.p4 << 16);
      a8    <= VAR1_OFFS + asr(asr(t13_7, 3) + asr(ap2_7, 1), 18);
      s8    <= s7;
      rp8   <= rp7;
      am9   <= 32'(a8 * cal.p1);
      bb9   <= bb8;
      s9    <= s8;
      rp9   <= rp8;
      div10 <= asr(am9, 15);
      pn10  <= (PRESS_BASE - rp9) - asr(bb9, 12);
      s10   <= s9;
      pm11  <= 32'(pn10 * PRESS_SCALE);
      div11 <= div10;
      s11   <= s10;
    end
  end

  always_comb begin
    side       = s11;
    side.halve = (pm11 >= SIGN_BIT);
    side.bad   = (div11 == '0);
    num        = side.halve ? pm11 : (pm11 << 1);
  end

  assign divisor   = div11;
  assign out_valid = v11;

endmodule

@@ src/ptc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage
module ptc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       num_in,
  input  logic [31:0]       divisor,
  input  ptc_pkg::side_t    side_in,
  output logic              out_valid,
  output logic [31:0]       quo,
  output ptc_pkg::side_t    side_out
);
  import ptc_pkg::*;

  logic        vld [0:DIV_STEPS];
  logic [31:0] rem [0:DIV_STEPS];
  logic [31:0] num [0:DIV_STEPS];
  logic [31:0] dvs [0:DIV_STEPS];
  side_t       sd  [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      num[0] <= num_in;
      dvs[0] <= divisor;
      sd[0]  <= side_in;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[k-1], num[k-1][31]};
    assign ge    = (trial >= {1'b0, dvs[k-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 32'(trial - {1'b0, dvs[k-1]}) : trial[31:0];
        num[k] <= {num[k-1][30:0], ge};
        dvs[k] <= dvs[k-1];
        sd[k]  <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign quo       = num[DIV_STEPS];
  assign side_out  = sd[DIV_STEPS];

endmodule

@@ src/ptc_back.sv @@
// Back pipeline: second-order pressure correction and output register
module ptc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ptc_pkg::calib_t       cal,
  input  logic                  in_valid,
  input  logic [31:0]           quo,
  input  ptc_pkg::side_t        side,
  ptc_result_if.source          result
);
  import ptc_pkg::*;

  logic        v1, v2, v3;
  logic [31:0] p0, p1r, qq1, bp1, p2r, am2, bp2;
  side_t       s1, s2;
  logic [31:0] q0;

  assign p0 = side.halve ? (quo << 1) : quo;
  assign q0 = p0 >> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3} <= '0;
    end else if (en) begin
      {v1, v2, v3} <= {in_valid, v1, v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1r <= p0;
      qq1 <= 32'(q0 * q0);
      bp1 <= 32'((p0 >> 2) * cal.p8);
      s1  <= side;
      p2r <= p1r;
      am2 <= 32'(cal.p9 * (qq1 >> 13));
      bp2 <= bp1;
      s2  <= s1;
      result.fine_temperature  <= s2.fine;
      result.temperature_centi <= s2.cent;
      result.pressure_invalid  <= s2.bad;
      result.pressure_pa       <= s2.bad ? '0 :
        p2r + asr(asr(am2, 12) + asr(bp2, 13) + cal.p7, 4);
    end
  end

  assign result.valid = v3;

endmodule

@@ src/pressure_temperature_compensation.sv @@
// Top level: calibration registers and the compensation pipeline
//
//   channel   dir  fields
//   sample    in   raw_temperature, raw_pressure
//   result    out  fine_temperature, temperature_centi, pressure_pa, pressure_invalid
//   cfg_*     in   cfg_we, cfg_index, cfg_wdata (write only)
//
// One sample per cycle while the result is not stalled; 11 front stages, 33 divider stages
// and 3 back stages, the divider producing one quotient bit per stage.
// rst clears all valid bits and the calibration registers.
// A waiting result stalls the whole pipeline; nothing is dropped or repeated.
module pressure_temperature_compensation (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_wdata,
  ptc_sample_if.sink     sample,
  ptc_result_if.source   result
);
  import ptc_pkg::*;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [15:0] press_calib_c;
  calib_t      cal;
  logic        en;
  logic        f_valid, d_valid;
  logic [31:0] f_num, f_div, d_quo;
  side_t       f_side, d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_TEMP_CALIB:    temp_calib    <= cfg_wdata[47:0];
        REG_PRESS_CALIB_A: press_calib_a <= cfg_wdata;
        REG_PRESS_CALIB_B: press_calib_b <= cfg_wdata;
        REG_PRESS_CALIB_C: press_calib_c <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = {16'd0, temp_calib[15:0]};
    cal.t2 = sx16(temp_calib[31:16]);
    cal.t3 = sx16(temp_calib[47:32]);
    cal.p1 = {16'd0, press_calib_a[15:0]};
    cal.p2 = sx16(press_calib_a[31:16]);
    cal.p3 = sx16(press_calib_a[47:32]);
    cal.p4 = sx16(press_calib_a[63:48]);
    cal.p5 = sx16(press_calib_b[15:0]);
    cal.p6 = sx16(press_calib_b[31:16]);
    cal.p7 = sx16(press_calib_b[47:32]);
    cal.p8 = sx16(press_calib_b[63:48]);
    cal.p9 = sx16(press_calib_c);
  end

  // pipeline advances whenever the output register is free or being taken
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  ptc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cal       (cal),
    .in_valid  (sample.valid),
    .rt        (sample.raw_temperature),
    .rp        (sample.raw_pressure),
    .out_valid (f_valid),
    .num       (f_num),
    .divisor   (f_div),
    .side      (f_side)
  );

  ptc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .num_in    (f_num),
    .divisor   (f_div),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quo       (d_quo),
    .side_out  (d_side)
  );

  ptc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cal      (cal),
    .in_valid (d_valid),
    .quo      (d_quo),
    .side     (d_side),
    .result   (result)
  );

endmodule

@@ tb/sv/pressure_temperature_compensation_test.sv @@
// Testbench: random and directed compensation samples checked against a built-in predictor
module pressure_temperature_compensation_test;
  import ptc_pkg::*;

  typedef struct packed {
    logic [19:0] rt;
    logic [19:0] rp;
  } sample_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] cent;
    logic [31:0] pa;
    logic        bad;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_TEMP_CALIB;
  logic [63:0] cfg_wdata = '0;

  ptc_sample_if sample();
  ptc_result_if result();

  pressure_temperature_compensation DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .sample(sample.sink), .result(result.source)
  );

  always #5 clk = ~clk;

  logic [47:0] cal_t;
  logic [63:0] cal_a, cal_b;
  logic [15:0] cal_c;

  sample_t pending_samples[$];
  comp_t   expected_results[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      settings_run = 0;
  bit      hold_off = 1'b0;

  function automatic logic [31:0] sar(logic [31:0] x, int s);
    logic signed [31:0] v;
    v = x;
    return 32'(v >>> s);
  endfunction

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(sample_t s);
    logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, d, q, p;
    comp_t r;
    rt = {12'd0, s.rt};
    rp = {12'd0, s.rp};
    t1 = {16'd0, cal_t[15:0]};
    t2 = ext16(cal_t[31:16]);
    t3 = ext16(cal_t[47:32]);
    p1 = {16'd0, cal_a[15:0]};
    p2 = ext16(cal_a[31:16]);
    p3 = ext16(cal_a[47:32]);
    p4 = ext16(cal_a[63:48]);
    p5 = ext16(cal_b[15:0]);
    p6 = ext16(cal_b[31:16]);
    p7 = ext16(cal_b[47:32]);
    p8 = ext16(cal_b[63:48]);
    p9 = ext16(cal_c);
    a = sar(((rt >> 3) - (t1 << 1)) * t2, 11);
    d = (rt >> 4) - t1;
    b = sar(sar(d * d, 12) * t3, 14);
    r.fine = a + b;
    r.cent = sar(r.fine * 32'd5 + 32'd128, 8);
    a = sar(r.fine, 1) - 32'd64000;
    q = sar(a, 2);
    b = sar(q * q, 11) * p6;
    b = b + ((a * p5) << 1);
    b = sar(b, 2) + (p4 << 16);
    a = sar(sar(p3 * sar(q * q, 13), 3) + sar(p2 * a, 1), 18);
    a = sar((32'd32768 + a) * p1, 15);
    if (a == 0) begin
      r.pa = '0;
      r.bad = 1'b1;
    end else begin
      r.bad = 1'b0;
      p = (32'd1048576 - rp) - sar(b, 12);
      p = p * 32'd3125;
      if (p < 32'h8000_0000) p = (p << 1) / a;
      else p = (p / a) << 1;
      q = p >> 3;
      a = sar(p9 * ((q * q) >> 13), 12);
      b = sar((p >> 2) * p8, 13);
      r.pa = p + sar(a + b + p7, 4);
    end
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // driver
  int drv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
      sample.raw_temperature <= '0;
      sample.raw_pressure <= '0;
    end else if (!sample.valid || sample.ready) begin
      if (sample.valid) expected_results.push_back(
          compensate({sample.raw_temperature, sample.raw_pressure}));
      if (drv_gap > 0) begin
        drv_gap <= drv_gap - 1;
        sample.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        sample.valid <= 1'b1;
        sample.raw_temperature <= s.rt;
        sample.raw_pressure <= s.rp;
        drv_gap <= gap_len();
      end else begin
        sample.valid <= 1'b0;
      end
    end
  end

  // monitor
  int mon_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        comp_t got, exp_r;
        got = {result.fine_temperature, result.temperature_centi,
               result.pressure_pa, result.pressure_invalid};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: fine %h/%h cent %h/%h pa %h/%h bad %b/%b (exp/act)",
                       exp_r.fine, got.fine, exp_r.cent, got.cent,
                       exp_r.pa, got.pa, exp_r.bad, got.bad);
          end
        end
      end
      if (hold_off) begin
        result.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        mon_gap <= gap_len();
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_TEMP_CALIB: cal_t = v[47:0];
      REG_PRESS_CALIB_A: cal_a = v;
      REG_PRESS_CALIB_B: cal_b = v;
      default: cal_c = v[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || sample.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_calib(logic [47:0] t, logic [63:0] a, logic [63:0] b, logic [15:0] c);
    write_reg(REG_TEMP_CALIB, {16'd0, t});
    write_reg(REG_PRESS_CALIB_A, a);
    write_reg(REG_PRESS_CALIB_B, b);
    write_reg(REG_PRESS_CALIB_C, {48'd0, c});
    settings_run++;
  endtask

  function automatic sample_t rand_sample();
    sample_t s;
    s.rt = $urandom_range(0, 2) == 0 ? 20'($urandom) : 20'($urandom_range(400000, 600000));
    s.rp = $urandom_range(0, 2) == 0 ? 20'($urandom) : 20'($urandom_range(250000, 450000));
    return s;
  endfunction

  initial begin
    cal_t = '0; cal_a = '0; cal_b = '0; cal_c = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // reset calibration: divisor zero, pressure flagged invalid
    pending_samples.push_back({20'h00000, 20'h00000});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
    drain();
    // typical datasheet-like coefficients
    load_calib({16'hFE18, 16'h6854, 16'd27504}, {16'h0FA0, 16'hD0D0, 16'hD6D0, 16'd36477},
               {16'h003C, 16'hFFF9, 16'h0060, 16'h0100}, 16'h1770);
    pending_samples.push_back({20'h00000, 20'h00000});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
    pending_samples.push_back({20'd519888, 20'd415148});
    pending_samples.push_back({20'h80000, 20'h7FFFF});
    pending_samples.push_back({20'h00000, 20'hFFFFF});
    pending_samples.push_back({20'hFFFFF, 20'h00000});
    drain();
    // extremes of every coefficient
    load_calib('1, '1, '1, '1);
    pending_samples.push_back({20'h00000, 20'h00000});
    pending_samples.push_back({20'hFFFFF, 20'hFFFFF});
    drain();
    load_calib({16'h8000, 16'h8000, 16'h7FFF}, {16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h8000);
    pending_samples.push_back({20'h00000, 20'hFFFFF});
    pending_samples.push_back({20'hFFFFF, 20'h00000});
    pending_samples.push_back({20'h55555, 20'hAAAAA});
    drain();
    // P1 zero forces the invalid-pressure path with live temperature
    load_calib({16'hFE18, 16'h6854, 16'd27504}, 64'hD0D0_D6D0_0000_0000, $urandom, 16'h1770);
    pending_samples.push_back({20'd519888, 20'd415148});
    pending_samples.push_back({20'hAAAAA, 20'h55555});
    drain();
    // random phases, the first with a long receiver hold-off
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 3)
        load_calib({16'hFE18 ^ 16'($urandom_range(0, 255)), 16'h6000 + 16'($urandom_range(0, 4095)),
                    16'd27000 + 16'($urandom_range(0, 1000))},
                   {16'hF000 | 16'($urandom), 16'($urandom), 16'hD000 | 16'($urandom),
                    16'd30000 + 16'($urandom_range(0, 10000))},
                   {$urandom, $urandom}, 16'($urandom));
      else
        load_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom));
      for (int i = 0; i < 72; i++) pending_samples.push_back(rand_sample());
      if (ph == 0) begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    $display("covered %0d calibration settings, %0d results incl. zero divisor and wrap cases",
             settings_run, results_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
